// ===== hw/rtl/keyframe_table_interpolator_assert.svh =====
// Assertion macros for the keyframe table interpolator
`ifndef KEYFRAME_TABLE_INTERPOLATOR_ASSERT_SVH
`define KEYFRAME_TABLE_INTERPOLATOR_ASSERT_SVH
`define KTI_ASSERT_IMPL(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("keyframe table check failed");
`define KTI_ASSERT_NEXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("keyframe table check failed");
`endif

// ===== hw/rtl/kti_pkg.sv =====
// Package with types, codes and constants of the keyframe table interpolator
`default_nettype none
package kti_pkg;
    localparam int KTI_MAX_KEYS = 64;

    typedef enum logic [2:0] {
        FN_ADD  = 3'd0,
        FN_DEL  = 3'd1,
        FN_FIND = 3'd2,
        FN_GET  = 3'd3,
        FN_NEAR = 3'd4,
        FN_PLAY = 3'd5
    } func_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_MOD,
        ST_DIV_SETUP,
        ST_DIV,
        ST_LERP,
        ST_EMIT_RD,
        ST_EMIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [15:0] key;
        logic [47:0] pos;
        logic [47:0] scl;
        logic [47:0] rot;
        logic        flag;
    } entry_t;

    function automatic logic [15:0] lerp_lane(input logic [15:0] a, input logic [15:0] b,
                                               input logic [15:0] f);
        logic signed [16:0] d;
        logic signed [34:0] t;
        logic signed [18:0] q;
        begin
            d = $signed({b[15], b}) - $signed({a[15], a});
            t = d * $signed({1'b0, f}) + 35'sd32768;
            q = t[34:16];
            lerp_lane = a + q[15:0];
        end
    endfunction

    function automatic logic [47:0] lerp3(input logic [47:0] a, input logic [47:0] b,
                                          input logic [15:0] f);
        logic [47:0] r;
        begin
            for (int n = 0; n < 3; n++)
                r[16*n +: 16] = lerp_lane(a[16*n +: 16], b[16*n +: 16], f);
            lerp3 = r;
        end
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/kti_divider.sv =====
// Restoring serial divider, one quotient bit per cycle, remainder too
`default_nettype none
module kti_divider
    import kti_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [39:0] dividend,
    input  wire logic [23:0] divisor,
    output logic             busy,
    output logic [39:0]      quotient,
    output logic [23:0]      remainder
);
    logic [39:0] q_reg;
    logic [24:0] r_reg;
    logic [5:0]  cnt_reg;
    logic [23:0] d_reg;
    logic [24:0] trial;

    assign trial = {r_reg[23:0], q_reg[39]} - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= 6'd40;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            if (!trial[24])
            begin
                r_reg <= trial;
                q_reg <= {q_reg[38:0], 1'b1};
            end
            else
            begin
                r_reg <= {r_reg[23:0], q_reg[39]};
                q_reg <= {q_reg[38:0], 1'b0};
            end
        end
    end

    assign busy = (cnt_reg != '0);
    assign quotient = q_reg;
    assign remainder = r_reg[23:0];
endmodule
`default_nettype wire

// ===== hw/rtl/keyframe_table_interpolator.sv =====
// Top level of the keyframe table interpolator
// Usage:
//   Input channel (in_valid/in_ready) carries one command word: func, key_number,
//   anim_pos, loop and the keyframe payload for add. Output channel
//   (out_valid/out_ready) returns exactly one result word per command.
//   The table is one synchronous memory of MAX_KEYS entries with a registered read port.
//   Commands are processed one at a time. A lookup scans the sorted table one
//   entry at a time (SCAN issues the read, SCAN_WAIT compares); adding a new key
//   or deleting a stored one then shifts the tail one entry at a time (read,
//   write). Play scans, may run the serial divider for the wrap modulo and
//   rescan, and runs it for the factor when it interpolates between two keys.
//   Reset empties the table at once (count cleared); no clearing pass.
//   The result waits in an output register while out_ready is low; the next
//   command is taken once it is delivered.
`default_nettype none
module keyframe_table_interpolator
    import kti_pkg::*;
#(
    parameter int MAX_KEYS = KTI_MAX_KEYS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  func,
    input  wire logic [15:0] key_number,
    input  wire logic [23:0] anim_pos,
    input  wire logic        loop,
    input  wire logic [47:0] position_in,
    input  wire logic [47:0] scale_in,
    input  wire logic [47:0] rotation_in,
    input  wire logic        not_playing_in,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             found,
    output logic             table_full,
    output logic [47:0]      position_out,
    output logic [47:0]      scale_out,
    output logic [47:0]      rotation_out,
    output logic             not_playing_out
);
    localparam int AW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);

    entry_t mem [MAX_KEYS];
    entry_t rd_q;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_q <= mem[rd_addr];
    end

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] j_reg, j_next;
    logic [2:0]  func_reg, func_next;
    logic [15:0] key_reg, key_next;
    logic [23:0] pos_reg, pos_next;
    logic        loop_reg, loop_next;
    logic        wrapped_reg, wrapped_next;
    entry_t      in_e_reg, in_e_next;
    entry_t      a_reg, a_next;
    entry_t      prev_reg, prev_next;
    logic [15:0] f_reg, f_next;
    logic        ov_reg, ov_next;
    logic        fnd_reg, fnd_next;
    logic        full_reg, full_next;
    logic [47:0] po_reg, po_next, so_reg, so_next, ro_reg, ro_next;
    logic        np_reg, np_next;

    logic        dv_start, dv_busy;
    logic [39:0] dv_dividend, dv_q;
    logic [23:0] dv_divisor, dv_r;

    kti_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_dividend),
        .divisor(dv_divisor), .busy(dv_busy), .quotient(dv_q), .remainder(dv_r)
    );

    logic        stop;
    logic [23:0] key_q8;
    assign key_q8 = {rd_q.key, 8'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next; j_reg <= j_next; func_reg <= func_next;
        key_reg <= key_next; pos_reg <= pos_next; loop_reg <= loop_next;
        wrapped_reg <= wrapped_next; in_e_reg <= in_e_next; a_reg <= a_next;
        prev_reg <= prev_next; f_reg <= f_next; fnd_reg <= fnd_next;
        full_reg <= full_next; po_reg <= po_next; so_reg <= so_next;
        ro_reg <= ro_next; np_reg <= np_next;
    end

    always_comb
    begin
        state_next = state_reg; cnt_next = cnt_reg; idx_next = idx_reg;
        j_next = j_reg; func_next = func_reg; key_next = key_reg;
        pos_next = pos_reg; loop_next = loop_reg; wrapped_next = wrapped_reg;
        in_e_next = in_e_reg; a_next = a_reg; prev_next = prev_reg;
        f_next = f_reg; ov_next = ov_reg; fnd_next = fnd_reg;
        full_next = full_reg; po_next = po_reg; so_next = so_reg;
        ro_next = ro_reg; np_next = np_reg;
        rd_addr = idx_reg[AW-1:0]; wr_en = 1'b0; wr_addr = j_reg[AW-1:0];
        wr_data = rd_q; dv_start = 1'b0;
        dv_dividend = {24'd0, pos_reg[15:0]}; dv_divisor = {prev_reg.key, 8'd0};
        in_ready = 1'b0;
        stop = 1'b0;
        if (func_reg == FN_PLAY)
            stop = (key_q8 > pos_reg);
        else
            stop = (rd_q.key >= key_reg);
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = !ov_reg;
                if (out_ready) ov_next = 1'b0;
                if (in_valid && !ov_reg)
                begin
                    func_next = func; key_next = key_number; pos_next = anim_pos;
                    loop_next = loop; wrapped_next = 1'b0;
                    in_e_next = '{key: key_number, pos: position_in, scl: scale_in,
                                  rot: rotation_in, flag: not_playing_in};
                    fnd_next = 1'b0; full_next = 1'b0;
                    po_next = '0; so_next = '0; ro_next = '0; np_next = 1'b0;
                    idx_next = '0;
                    if (func > FN_PLAY || (func == FN_PLAY && cnt_reg == '0))
                        state_next = ST_OUT;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == cnt_reg)
                    state_next = ST_SCAN_WAIT;
                else
                begin
                    rd_addr = idx_reg[AW-1:0];
                    state_next = ST_SCAN_WAIT;
                end
            end
            ST_SCAN_WAIT:
            begin
                if (idx_reg != cnt_reg && !stop)
                begin
                    prev_next = rd_q;
                    idx_next = idx_reg + 1'b1;
                    state_next = ST_SCAN;
                end
                else
                begin
                    a_next = rd_q;
                    unique case (func_reg)
                        FN_PLAY:
                        begin
                            fnd_next = 1'b1;
                            if (idx_reg == cnt_reg)
                            begin
                                if (!loop_reg || prev_reg.key == 16'd0 || wrapped_reg)
                                begin
                                    idx_next = cnt_reg - 1'b1;
                                    state_next = ST_EMIT_RD;
                                end
                                else
                                begin
                                    dv_start = 1'b1;
                                    dv_dividend = {16'd0, pos_reg};
                                    dv_divisor = {prev_reg.key, 8'd0};
                                    state_next = ST_MOD;
                                end
                            end
                            else if (idx_reg == '0)
                                state_next = ST_EMIT_RD;
                            else
                                state_next = ST_DIV_SETUP;
                        end
                        default:
                        begin
                            if (idx_reg != cnt_reg && rd_q.key == key_reg)
                            begin
                                fnd_next = 1'b1;
                                unique case (func_reg) inside
                                    FN_ADD:
                                    begin
                                        wr_en = 1'b1; wr_addr = idx_reg[AW-1:0];
                                        wr_data = in_e_reg;
                                        state_next = ST_OUT;
                                    end
                                    FN_DEL:
                                    begin
                                        j_next = idx_reg;
                                        state_next = ST_SHIFT_RD;
                                    end
                                    FN_GET, FN_NEAR:
                                    begin
                                        po_next = rd_q.pos; so_next = rd_q.scl;
                                        ro_next = rd_q.rot; np_next = rd_q.flag;
                                        state_next = ST_OUT;
                                    end
                                    default: state_next = ST_OUT;
                                endcase
                            end
                            else
                            begin
                                state_next = ST_OUT;
                                if (func_reg == FN_ADD)
                                begin
                                    if (cnt_reg == CW'(MAX_KEYS))
                                        full_next = 1'b1;
                                    else
                                    begin
                                        j_next = cnt_reg;
                                        state_next = ST_SHIFT_RD;
                                    end
                                end
                                else if (func_reg == FN_NEAR && idx_reg != '0)
                                begin
                                    fnd_next = 1'b1;
                                    po_next = prev_reg.pos; so_next = prev_reg.scl;
                                    ro_next = prev_reg.rot; np_next = prev_reg.flag;
                                end
                            end
                        end
                    endcase
                end
            end
            ST_SHIFT_RD:
            begin
                if (func_reg == FN_ADD)
                begin
                    if (j_reg == idx_reg)
                    begin
                        wr_en = 1'b1; wr_addr = idx_reg[AW-1:0]; wr_data = in_e_reg;
                        cnt_next = cnt_reg + 1'b1;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        rd_addr = AW'(j_reg - 1'b1);
                        state_next = ST_SHIFT_WR;
                    end
                end
                else
                begin
                    if (j_reg + 1'b1 >= cnt_reg)
                    begin
                        cnt_next = cnt_reg - 1'b1;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        rd_addr = AW'(j_reg + 1'b1);
                        state_next = ST_SHIFT_WR;
                    end
                end
            end
            ST_SHIFT_WR:
            begin
                wr_en = 1'b1; wr_addr = j_reg[AW-1:0]; wr_data = rd_q;
                j_next = (func_reg == FN_ADD) ? j_reg - 1'b1 : j_reg + 1'b1;
                state_next = ST_SHIFT_RD;
            end
            ST_MOD:
            begin
                if (!dv_busy && !dv_start)
                begin
                    pos_next = dv_r;
                    wrapped_next = 1'b1;
                    idx_next = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_DIV_SETUP:
            begin
                dv_start = 1'b1;
                dv_dividend = {pos_reg - {prev_reg.key, 8'd0}, 16'd0};
                dv_divisor = {a_reg.key - prev_reg.key, 8'd0};
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!dv_busy)
                begin
                    f_next = (dv_q[39:16] != '0) ? 16'hFFFF : dv_q[15:0];
                    state_next = ST_LERP;
                end
            end
            ST_LERP:
            begin
                po_next = lerp3(prev_reg.pos, a_reg.pos, f_reg);
                so_next = lerp3(prev_reg.scl, a_reg.scl, f_reg);
                ro_next = lerp3(prev_reg.rot, a_reg.rot, f_reg);
                np_next = prev_reg.flag;
                state_next = ST_OUT;
            end
            ST_EMIT_RD:
            begin
                rd_addr = idx_reg[AW-1:0];
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                po_next = rd_q.pos; so_next = rd_q.scl; ro_next = rd_q.rot;
                np_next = rd_q.flag;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                ov_next = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_valid = ov_reg;
    assign found = fnd_reg;
    assign table_full = full_reg;
    assign position_out = po_reg;
    assign scale_out = so_reg;
    assign rotation_out = ro_reg;
    assign not_playing_out = np_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/kti_checker.sv =====
// Port checker for the keyframe table interpolator, with its bind
`default_nettype none
`include "keyframe_table_interpolator_assert.svh"
module kti_checker
    import kti_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        found,
    input wire logic        table_full,
    input wire logic [47:0] position_out
);
    `KTI_ASSERT_IMPL(a_busy_while_out, clk, rst_n, out_valid, !in_ready)
    `KTI_ASSERT_NEXT(a_accept_drops_ready, clk, rst_n, in_valid && in_ready, !in_ready)
    `KTI_ASSERT_IMPL(a_full_no_hit, clk, rst_n, out_valid && table_full, !found)
    `KTI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                     out_valid && $stable(position_out))
endmodule

bind keyframe_table_interpolator kti_checker u_kti_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .found(found),
    .table_full(table_full), .position_out(position_out)
);
`default_nettype wire

// ===== tb/keyframe_table_interpolator_test.sv =====
// Testbench for the keyframe table interpolator: directed and random commands checked against a predictor
`timescale 1ns / 1ps
`default_nettype none

class keyframe_scoreboard;
    logic [15:0] keys[$];
    logic [47:0] pos[$];
    logic [47:0] scl[$];
    logic [47:0] rot[$];
    logic        flg[$];
    logic [146:0] pending[$];
    int max_keys;
    int errors;

    function new(int depth);
        max_keys = depth;
        errors = 0;
    endfunction

    function automatic logic [15:0] lerp_lane(logic [15:0] a, logic [15:0] b, logic [16:0] f);
        longint la, d, t, q;
        la = longint'($signed(a));
        d = longint'($signed(b)) - la;
        t = d * longint'(f) + 32768;
        q = t >= 0 ? t / 65536 : -((-t + 65535) / 65536);
        return 16'(la + q);
    endfunction

    function automatic logic [47:0] lerp_word(logic [47:0] a, logic [47:0] b, logic [16:0] f);
        logic [47:0] r;
        for (int n = 0; n < 3; n++)
            r[16*n +: 16] = lerp_lane(a[16*n +: 16], b[16*n +: 16], f);
        return r;
    endfunction

    function automatic int lower_of(logic [15:0] k);
        int i;
        i = 0;
        while (i < keys.size() && keys[i] < k) i++;
        return i;
    endfunction

    function automatic int upper_of(longint p);
        int i;
        i = 0;
        while (i < keys.size() && (longint'(keys[i]) << 8) <= p) i++;
        return i;
    endfunction

    function automatic logic [146:0] entry_word(logic fnd, int i);
        return {fnd, 1'b0, pos[i], scl[i], rot[i], flg[i]};
    endfunction

    function void note_command(logic [2:0] fn, logic [15:0] k, logic [23:0] ap, logic lp,
                               logic [47:0] p, logic [47:0] s, logic [47:0] r, logic np);
        logic [146:0] res;
        int i, n, i0, i1;
        logic hit;
        longint q, last, span, off, f;
        res = '0;
        n = keys.size();
        if (fn == kti_pkg::FN_PLAY) begin
            if (n > 0) begin
                q = ap;
                i1 = upper_of(q);
                if (i1 == n) begin
                    last = longint'(keys[n-1]) << 8;
                    if (!lp || last == 0) i1 = -1;
                    else begin
                        q = q % last;
                        i1 = upper_of(q);
                    end
                end
                if (i1 == -1 || i1 >= n) res = entry_word(1'b1, n - 1);
                else if (i1 == 0) res = entry_word(1'b1, 0);
                else begin
                    i0 = i1 - 1;
                    span = (longint'(keys[i1]) - keys[i0]) << 8;
                    off = q - (longint'(keys[i0]) << 8);
                    f = span ? (off << 16) / span : 0;
                    if (f > 65535) f = 65535;
                    res = {1'b1, 1'b0, lerp_word(pos[i0], pos[i1], 17'(f)),
                           lerp_word(scl[i0], scl[i1], 17'(f)),
                           lerp_word(rot[i0], rot[i1], 17'(f)), flg[i0]};
                end
            end
        end else if (fn <= kti_pkg::FN_NEAR) begin
            i = lower_of(k);
            hit = i < n && keys[i] == k;
            res[146] = hit;
            case (fn)
                kti_pkg::FN_ADD:
                    if (hit) begin
                        pos[i] = p; scl[i] = s; rot[i] = r; flg[i] = np;
                    end else if (n >= max_keys) res[145] = 1'b1;
                    else begin
                        keys.insert(i, k); pos.insert(i, p); scl.insert(i, s);
                        rot.insert(i, r); flg.insert(i, np);
                    end
                kti_pkg::FN_DEL:
                    if (hit) begin
                        keys.delete(i); pos.delete(i); scl.delete(i);
                        rot.delete(i); flg.delete(i);
                    end
                kti_pkg::FN_GET:
                    if (hit) res = entry_word(1'b1, i);
                kti_pkg::FN_NEAR:
                    if (hit) res = entry_word(1'b1, i);
                    else if (i > 0) res = entry_word(1'b1, i - 1);
                default: ;
            endcase
        end
        pending.push_back(res);
    endfunction

    task report(string what, logic [47:0] got, logic [47:0] want);
        $display("field %s: got %h, expected %h", what, got, want);
        errors++;
    endtask

    task check_result(logic fnd, logic full, logic [47:0] p, logic [47:0] s,
                      logic [47:0] r, logic np);
        logic [146:0] w;
        if (pending.size() == 0) begin
            report("unexpected word", 0, 0);
            return;
        end
        w = pending.pop_front();
        if (fnd !== w[146]) report("found", fnd, w[146]);
        if (full !== w[145]) report("table_full", full, w[145]);
        if (p !== w[144:97]) report("position_out", p, w[144:97]);
        if (s !== w[96:49]) report("scale_out", s, w[96:49]);
        if (r !== w[48:1]) report("rotation_out", r, w[48:1]);
        if (np !== w[0]) report("not_playing_out", np, w[0]);
    endtask
endclass

module keyframe_table_interpolator_test;
    import kti_pkg::*;

    localparam int TOTAL = 1900;
    localparam int WATCHDOG = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [2:0] func = '0;
    logic [15:0] key_number = '0;
    logic [23:0] anim_pos = '0;
    logic loop = 1'b0;
    logic [47:0] position_in = '0;
    logic [47:0] scale_in = '0;
    logic [47:0] rotation_in = '0;
    logic not_playing_in = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic found, table_full, not_playing_out;
    logic [47:0] position_out, scale_out, rotation_out;

    keyframe_scoreboard board = new(KTI_MAX_KEYS);
    int idle_cycles = 0;
    int sent = 0;
    int stall_left = 0;
    bit calm = 1'b0;

    always #10 clk = ~clk;

    keyframe_table_interpolator dut (.*);

    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready)
            board.note_command(func, key_number, anim_pos, loop, position_in, scale_in,
                               rotation_in, not_playing_in);
        if (rst_n && out_valid && out_ready)
            board.check_result(found, table_full, position_out, scale_out, rotation_out,
                               not_playing_out);
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("keyframe_table_interpolator: mismatch");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (rst_n && !calm && $urandom_range(0, 5) == 0) begin
            out_ready <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end else out_ready <= 1'b1;
    end

    function automatic logic [47:0] rand48();
        return {16'($urandom), $urandom};
    endfunction

    task send(logic [2:0] fn, logic [15:0] k, logic [23:0] ap, logic lp);
        if (!calm && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        func <= fn;
        key_number <= k;
        anim_pos <= ap;
        loop <= lp;
        position_in <= rand48();
        scale_in <= rand48();
        rotation_in <= rand48();
        not_playing_in <= 1'($urandom);
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent++;
    endtask

    function automatic logic [15:0] pick_key();
        case ($urandom_range(0, 5))
            0: return 16'hFFFF;
            1: return 16'($urandom_range(0, 3));
            2: return 16'($urandom);
            default: return 16'($urandom_range(0, 40) * 4);
        endcase
    endfunction

    task drain();
        int n;
        n = 0;
        in_valid <= 1'b0;
        while (board.pending.size() != 0 && n < WATCHDOG) begin
            @(posedge clk);
            n++;
        end
    endtask

    initial begin
        int r;
        logic [2:0] fn;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send(FN_PLAY, 0, 24'hFFFFFF, 1);
        send(FN_NEAR, 5, 0, 0);
        send(FN_DEL, 5, 0, 0);
        send(FN_ADD, 0, 0, 0);
        send(FN_PLAY, 0, 24'h000080, 1);
        send(FN_ADD, 16'hFFFF, 0, 0);
        send(FN_ADD, 100, 0, 0);
        send(FN_ADD, 100, 0, 0);
        send(FN_FIND, 100, 0, 0);
        send(FN_GET, 100, 0, 0);
        send(FN_GET, 99, 0, 0);
        send(FN_NEAR, 150, 0, 0);
        send(FN_PLAY, 0, 24'd50 << 8, 0);
        send(FN_PLAY, 0, 24'd100 << 8, 0);
        send(FN_PLAY, 0, 24'hFFFFFF, 1);
        send(FN_PLAY, 0, 24'hFFFFFF, 0);
        send(3'd6, 1, 0, 0);
        send(3'd7, 1, 0, 0);
        send(FN_DEL, 16'hFFFF, 0, 0);
        send(FN_PLAY, 0, 24'h0100FF, 1);
        drain();
        for (int i = 0; i < 70; i++) send(FN_ADD, 16'(i * 7 + 1), 0, 0);
        send(FN_PLAY, 0, 24'($urandom), 1);
        for (int i = 0; i < 70; i++) send(FN_DEL, 16'(i * 7 + 1), 0, 0);
        drain();
        while (sent < TOTAL) begin
            if (sent > TOTAL - 150) calm = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 30) fn = FN_ADD;
            else if (r < 42) fn = FN_DEL;
            else if (r < 50) fn = FN_FIND;
            else if (r < 58) fn = FN_GET;
            else if (r < 66) fn = FN_NEAR;
            else if (r < 98) fn = FN_PLAY;
            else fn = 3'($urandom_range(6, 7));
            if ($urandom_range(0, 3) == 0) send(fn, pick_key(), 24'($urandom), 1'($urandom));
            else send(fn, pick_key(), 24'($urandom_range(0, 170 << 8)), 1'($urandom));
            if (sent == 900) drain();
        end
        drain();
        repeat (300) @(posedge clk);
        if (board.pending.size() == 0 && board.errors == 0)
            $display("keyframe_table_interpolator: match");
        else
            $display("keyframe_table_interpolator: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
